// File: design/ssq_pkg.sv
`timescale 1ns / 1ps

package ssq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int THREAD_ID_BITS = 8;

   localparam int TICK_BITS      = 64;
   localparam int WAKE_OUT_BITS  = 63;
   localparam int TID_PORT_BITS  = 8;
   localparam int DURATION_BITS  = 32;
   localparam int STATUS_BITS    = 2;
   localparam int TID_BITS       = (THREAD_ID_BITS < TID_PORT_BITS) ? THREAD_ID_BITS
                                                                    : TID_PORT_BITS;
   localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_SLEEP = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic KIND_WOKEN = 1'b0;
   localparam logic KIND_ACK   = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_IGNORED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   typedef struct packed {
      logic [TICK_BITS-1:0] wake;
      logic [TID_BITS-1:0]  tid;
   } entry_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [TICK_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

// File: design/ssq_cell.sv
`timescale 1ns / 1ps

module ssq_cell (
   input  logic                  clock,
   input  ssq_pkg::cell_ctrl_type ctrl,
   input  logic                  valid,
   input  logic                  le_prev,
   input  ssq_pkg::entry_type    new_entry,
   input  ssq_pkg::entry_type    left_entry,
   input  ssq_pkg::entry_type    right_entry,
   output ssq_pkg::entry_type    entry,
   output logic                  le
);
   import ssq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // entry is live and not later than the key
   assign le    = valid && (entry_ff.wake <= ctrl.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (!le) begin
               if (le_prev) begin
                  entry_in = new_entry;
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: design/sorted_sleep_wakeup_queue_core.sv
`timescale 1ns / 1ps

// Sorted sleep / wake-up queue. A 64-bit tick count, bumped by each tick beat,
// and a row of QUEUE_DEPTH cells holding sleeping thread ids in wake-time
// order. A sleep beat does the wake-time add, then a parallel insert across
// the cell row when the sleep is positive and the row not full, and yields
// one acknowledge beat. A tick beat bumps the count, then pops the woken
// threads one at a time (the row shifts one slot toward the head on each
// pop); the last woken beat carries last. The input is taken again once the
// current beat's work is done, even while a result still waits in the output
// register. A stall on the result side holds the insert and each pop.

module sorted_sleep_wakeup_queue_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [ssq_pkg::TID_PORT_BITS-1:0]    req_thread_id,
   input  logic signed [ssq_pkg::DURATION_BITS-1:0] req_sleep_ticks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_kind,
   output logic [ssq_pkg::TID_PORT_BITS-1:0]    rsp_thread_id_res,
   output logic [ssq_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [ssq_pkg::WAKE_OUT_BITS-1:0]    rsp_wake_tick,
   output logic                                 rsp_last
);
   import ssq_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SLEEP = 2'd1;
   localparam logic [1:0] ST_POP   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TICK_BITS-1:0]  tick_ff, tick_in;
   logic [TICK_BITS-1:0]  wake_ff, wake_in;
   logic [TID_BITS-1:0]   tid_ff, tid_in;
   logic                  pos_ff, pos_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [TID_PORT_BITS-1:0] rsp_tid_ff, rsp_tid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [WAKE_OUT_BITS-1:0] rsp_wake_ff, rsp_wake_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     cell_entry [QUEUE_DEPTH];
   logic          cell_le    [QUEUE_DEPTH];
   logic          out_free;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_thread_id_res = rsp_tid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_wake_tick     = rsp_wake_ff;
   assign rsp_last          = rsp_last_ff;

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign new_entry.wake = wake_ff;
   assign new_entry.tid  = tid_ff;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         entry_type left_e;
         entry_type right_e;
         logic      le_prev;
         logic      valid;

         assign valid = (COUNT_BITS'(gi) < count_ff);

         if (gi == 0) begin : g_head
            assign left_e  = new_entry;
            assign le_prev = 1'b1;
         end else begin : g_body
            assign left_e  = cell_entry[gi-1];
            assign le_prev = cell_le[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right_e = cell_entry[gi];
         end else begin : g_inner
            assign right_e = cell_entry[gi+1];
         end

         ssq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .valid       (valid),
            .le_prev     (le_prev),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[gi]),
            .le          (cell_le[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      tick_in       = tick_ff;
      wake_in       = wake_ff;
      tid_in        = tid_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tid_in    = rsp_tid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_wake_in   = rsp_wake_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl.op       = OP_HOLD;
      ctrl.key      = (state_ff == ST_POP) ? tick_ff : wake_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               tid_in = req_thread_id[TID_BITS-1:0];
               if (req_command == CMD_TICK) begin
                  tick_in  = tick_ff + TICK_BITS'(1);
                  state_in = ST_POP;
               end else begin
                  wake_in  = tick_ff + {{(TICK_BITS-DURATION_BITS){1'b0}}, req_sleep_ticks};
                  pos_in   = !req_sleep_ticks[DURATION_BITS-1] && (req_sleep_ticks != '0);
                  state_in = ST_SLEEP;
               end
            end
         end
         ST_SLEEP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_tid_in   = TID_PORT_BITS'(tid_ff);
               rsp_last_in  = 1'b1;
               if (!pos_ff) begin
                  rsp_status_in = STATUS_IGNORED;
                  rsp_wake_in   = '0;
               end else if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_wake_in   = wake_ff[WAKE_OUT_BITS-1:0];
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_wake_in   = wake_ff[WAKE_OUT_BITS-1:0];
                  ctrl.op       = OP_INSERT;
                  count_in      = count_ff + COUNT_BITS'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (!cell_le[0]) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_WOKEN;
               rsp_tid_in    = TID_PORT_BITS'(cell_entry[0].tid);
               rsp_status_in = STATUS_OK;
               rsp_wake_in   = cell_entry[0].wake[WAKE_OUT_BITS-1:0];
               rsp_last_in   = !cell_le[1];
               ctrl.op       = OP_POP;
               count_in      = count_ff - COUNT_BITS'(1);
               if (!cell_le[1]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff       <= wake_in;
      tid_ff        <= tid_in;
      pos_ff        <= pos_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tid_ff    <= rsp_tid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wake_ff   <= rsp_wake_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
